[design/slri_pkg.sv]
package slri_pkg;

    // Operation codes carried in the input tuser field.
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    // Fixed field widths of the stream words.
    localparam int IN_KEY_W   = 32;
    localparam int POS_W      = 4;
    localparam int TOTAL_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage

[design/slri_cell.sv]
module slri_cell import slri_pkg::*; #(
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 5,
    parameter int INDEX     = 0
) (
    input  logic                        i_clk,
    input  t_cell_ctl                   i_ctl,
    input  logic [CNT_W-1:0]            i_count,
    input  logic [POS_W-1:0]            i_pos,
    input  logic signed [KEY_WIDTH-1:0] i_new_key,
    input  logic signed [KEY_WIDTH-1:0] i_left_key,
    input  logic                        i_left_sel,
    input  logic signed [KEY_WIDTH-1:0] i_right_key,
    output logic signed [KEY_WIDTH-1:0] o_key,
    output logic                        o_sel
);

    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] n_key;
    logic                        w_empty;
    logic                        w_at_or_above;

    // An empty slot counts as larger than any key, so the insert point is
    // the first cell whose key is strictly greater than the new one.
    assign w_empty       = (INDEX >= int'(i_count));
    assign o_sel         = w_empty || (r_key > i_new_key);
    assign w_at_or_above = (INDEX >= int'(i_pos));
    assign o_key         = r_key;

    // Insert shifts up from the left neighbor; remove shifts down from the right.
    always_comb begin
        n_key = r_key;
        if (i_ctl.insert && o_sel) begin
            n_key = i_left_sel ? i_left_key : i_new_key;
        end else if (i_ctl.remove && w_at_or_above) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

[design/sorted_list_insert_remove_unit.sv]
// Sorted key list. Keys are held in ascending order in a row of cells,
// one key per cell, and each cell exchanges its key with its neighbors.
// Input channel (i_s_*): one word per operation. tuser carries the kind
// (insert, remove at position, read at position); tdata carries the key
// to insert and the position.
// Output channel (o_m_*): one word per operation with the key read, the
// number of keys held after the operation, and a status code (ok, store
// full on insert, position out of range on remove or read).
// The result word appears on the output register in the cycle after input
// acceptance. One operation is accepted every cycle while the receiver
// takes results: the whole row of cells compares against the new key and
// shifts in the same cycle, and the single output register holds the result.
// While the receiver stalls, the result stays on the output register and
// o_s_tready drops, so no word is lost. A new word is taken in the cycle
// the held result is taken.
// Reset clears the key count and the output valid; cell contents are not
// cleared, since only cells below the count are ever read.
module sorted_list_insert_remove_unit import slri_pkg::*; #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [31:0] key_value, [35:32] position, [39:36] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] kind
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [31:0] read_key, [36:32] entry_total, [38:37] status, [39] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                        w_accept;
    t_kind                       w_kind;
    logic signed [IN_KEY_W-1:0]  w_in_key;
    logic [POS_W-1:0]            w_pos;
    logic [KEY_WIDTH+IN_KEY_W-1:0] w_key_ext;
    logic signed [KEY_WIDTH-1:0] w_new_key;
    logic                        w_full;
    logic                        w_pos_ok;
    t_cell_ctl                   w_ctl;
    logic signed [KEY_WIDTH-1:0] w_key [CAPACITY];
    logic                        w_sel [CAPACITY];
    logic signed [KEY_WIDTH-1:0] w_read_sel;
    logic [KEY_WIDTH+IN_KEY_W-1:0] w_read_ext;
    logic [CNT_W+TOTAL_W-1:0]    w_total_ext;

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic                        r_out_valid;
    logic signed [IN_KEY_W-1:0]  r_read_key;
    logic signed [IN_KEY_W-1:0]  n_read_key;
    logic [TOTAL_W-1:0]          r_total;
    t_status                     r_status;
    t_status                     n_status;

    // Input word unpacking.
    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_kind    = t_kind'(i_s_tuser);
    assign w_in_key  = i_s_tdata[IN_KEY_W-1:0];
    assign w_pos     = i_s_tdata[IN_KEY_W+POS_W-1:IN_KEY_W];
    assign w_key_ext = {{KEY_WIDTH{w_in_key[IN_KEY_W-1]}}, w_in_key};
    assign w_new_key = w_key_ext[KEY_WIDTH-1:0];

    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_pos_ok = (int'(w_pos) < int'(r_count));

    // Operation decode and result formation.
    always_comb begin
        w_ctl      = '0;
        n_count    = r_count;
        n_status   = STATUS_OK;
        n_read_key = '0;
        case (w_kind)
            KIND_INSERT: begin
                if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    w_ctl.insert = w_accept;
                    n_count      = r_count + 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (!w_pos_ok) begin
                    n_status = STATUS_RANGE;
                end else begin
                    w_ctl.remove = w_accept;
                    n_count      = r_count - 1'b1;
                end
            end
            KIND_READ: begin
                if (!w_pos_ok) begin
                    n_status = STATUS_RANGE;
                end else begin
                    n_read_key = w_read_ext[IN_KEY_W-1:0];
                end
            end
            default: begin
                n_status = STATUS_OK;
            end
        endcase
    end

    // Row of key cells.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_WIDTH-1:0] w_left_key;
        logic                        w_left_sel;
        logic signed [KEY_WIDTH-1:0] w_right_key;

        if (g == 0) begin : g_first
            assign w_left_key = w_new_key;
            assign w_left_sel = 1'b0;
        end else begin : g_inner
            assign w_left_key = w_key[g-1];
            assign w_left_sel = w_sel[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_key = w_key[g];
        end else begin : g_body
            assign w_right_key = w_key[g+1];
        end

        slri_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .INDEX     (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_pos       (w_pos),
            .i_new_key   (w_new_key),
            .i_left_key  (w_left_key),
            .i_left_sel  (w_left_sel),
            .i_right_key (w_right_key),
            .o_key       (w_key[g]),
            .o_sel       (w_sel[g])
        );
    end

    // Read select across the row.
    always_comb begin
        w_read_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == int'(w_pos)) begin
                w_read_sel = w_key[i];
            end
        end
    end

    assign w_read_ext  = {{IN_KEY_W{w_read_sel[KEY_WIDTH-1]}}, w_read_sel};
    assign w_total_ext = {{TOTAL_W{1'b0}}, n_count};

    // Flow control: take a word when the output register is free or emptying.
    assign o_s_tready = !r_out_valid || i_m_tready;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (o_s_tready) begin
                r_out_valid <= i_s_tvalid;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_key <= n_read_key;
            r_total    <= w_total_ext[TOTAL_W-1:0];
            r_status   <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_status, r_total, r_read_key};

endmodule

[design/slri_checker.sv]
module slri_checker import slri_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [IN_DATA_W-1:0]  i_s_tdata,
    input logic [1:0]            i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam logic [TOTAL_W+8:0] CAP_TOTAL = (TOTAL_W + 9)'(CAPACITY % 32);

    logic [IN_KEY_W-1:0] w_read_key;
    logic [TOTAL_W-1:0]  w_total;
    logic [STATUS_W-1:0] w_status;

    assign w_read_key = o_m_tdata[IN_KEY_W-1:0];
    assign w_total    = o_m_tdata[IN_KEY_W+TOTAL_W-1:IN_KEY_W];
    assign w_status   = o_m_tdata[IN_KEY_W+TOTAL_W+STATUS_W-1:IN_KEY_W+TOTAL_W];

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result word changed while stalled");

    // The output register never blocks input when it is empty.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input not ready with empty output");

    // A full status comes only with a count equal to the capacity.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_status == STATUS_FULL) |->
            ((TOTAL_W + 9)'(w_total) == CAP_TOTAL))
        else $error("full status without full count");

    // Failed operations return no key.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_status == STATUS_FULL || w_status == STATUS_RANGE)) |->
            (w_read_key == '0))
        else $error("nonzero key on failed operation");

    // Status codes stay within the defined set.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_status == STATUS_OK || w_status == STATUS_FULL
                        || w_status == STATUS_RANGE))
        else $error("undefined status code");

endmodule

bind sorted_list_insert_remove_unit slri_checker #(.CAPACITY(CAPACITY)) u_slri_checker (.*);

[sim/sorted_list_insert_remove_unit_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the sorted list, keeps its own copy of the list,
// and compares every result word with the oldest predicted word.
module sorted_list_insert_remove_unit_checker import slri_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // [31:0] key_value, [35:32] position, [39:36] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] kind
    input  logic [1:0]            i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // [31:0] read_key, [36:32] entry_total, [38:37] status, [39] zero
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam int LIST_DEPTH = 16;

    typedef struct packed {
        logic signed [IN_KEY_W-1:0] read_key;
        logic [TOTAL_W-1:0]         entry_total;
        t_status                    status;
    } t_list_result;

    logic signed [IN_KEY_W-1:0] sorted_keys [LIST_DEPTH];
    int                         key_total = 0;
    t_list_result               result_queue [$];
    t_list_result               expected_word;
    t_list_result               actual_word;

    // Applies one operation to the shadow list and returns the word it yields.
    task automatic apply_list_op(
        input  logic [1:0]                kind,
        input  logic signed [IN_KEY_W-1:0] key,
        input  logic [POS_W-1:0]          pos,
        output t_list_result              res
    );
        int slot;
        int idx;
        res.read_key = '0;
        res.status   = STATUS_OK;
        case (kind)
            KIND_INSERT: begin
                if (key_total >= LIST_DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    // A new key lands after every key less than or equal to it.
                    slot = 0;
                    while (slot < key_total && sorted_keys[slot] <= key)
                        slot++;
                    for (idx = key_total; idx > slot; idx--)
                        sorted_keys[idx] = sorted_keys[idx - 1];
                    sorted_keys[slot] = key;
                    key_total++;
                end
            end
            KIND_REMOVE: begin
                if (int'(pos) >= key_total) begin
                    res.status = STATUS_RANGE;
                end else begin
                    for (idx = int'(pos); idx + 1 < key_total; idx++)
                        sorted_keys[idx] = sorted_keys[idx + 1];
                    key_total--;
                end
            end
            KIND_READ: begin
                if (int'(pos) >= key_total)
                    res.status = STATUS_RANGE;
                else
                    res.read_key = sorted_keys[pos];
            end
            default: begin
                // The unused kind leaves the list alone and reports ok.
            end
        endcase
        res.entry_total = TOTAL_W'(key_total);
    endtask

    // Results are checked before the word taken at the same edge is predicted,
    // since a word can never come out in the cycle it goes in.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_total    = 0;
            o_mismatches = 0;
            result_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                actual_word.read_key    = i_m_tdata[31:0];
                actual_word.entry_total = i_m_tdata[36:32];
                actual_word.status      = t_status'(i_m_tdata[38:37]);
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result word, got %h", $time, i_m_tdata);
                    o_mismatches++;
                end else begin
                    expected_word = result_queue.pop_front();
                    if (actual_word.read_key !== expected_word.read_key) begin
                        $display("%0t: read_key expected %0d, got %0d", $time,
                                 expected_word.read_key, actual_word.read_key);
                        o_mismatches++;
                    end
                    if (actual_word.entry_total !== expected_word.entry_total) begin
                        $display("%0t: entry_total expected %0d, got %0d", $time,
                                 expected_word.entry_total, actual_word.entry_total);
                        o_mismatches++;
                    end
                    if (actual_word.status !== expected_word.status) begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 expected_word.status, actual_word.status);
                        o_mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_list_op(i_s_tuser, i_s_tdata[31:0], i_s_tdata[35:32], expected_word);
                result_queue.push_back(expected_word);
            end
        end
        o_pending = result_queue.size();
    end

endmodule

[sim/sorted_list_insert_remove_unit_tb.sv]
`timescale 1ns / 100ps

// Drives list operations into the sorted list under several idle patterns;
// the checker beside the block predicts and compares every result word.
module sorted_list_insert_remove_unit_tb;
    import slri_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         PHASE_WORDS = 312;
    localparam int         HOLD_CYCLES = 300;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // [31:0] key_value, [35:32] position, [39:36] zero
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    // [1:0] kind
    logic [1:0]            i_s_tuser  = KIND_INSERT;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [31:0] read_key, [36:32] entry_total, [38:37] status, [39] zero
    logic [OUT_DATA_W-1:0] o_m_tdata;

    int mismatch_count;
    int results_pending;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int hold_served        = 0;
    int hold_left          = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sorted_list_insert_remove_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    sorted_list_insert_remove_unit_checker list_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_mismatches (mismatch_count),
        .o_pending    (results_pending)
    );

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offers one word, with random idle cycles first, and waits until it is taken.
    task automatic send_op(input logic [1:0] kind, input logic [31:0] key,
                           input logic [3:0] pos);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {4'b0000, pos, key};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    // Random operation; small keys make duplicates common.
    task automatic send_random_op(input int insert_pct);
        int          pick;
        int          key_mode;
        logic [1:0]  kind;
        logic [31:0] key;
        pick     = $urandom_range(99);
        key_mode = $urandom_range(9);
        if (pick < insert_pct)
            kind = KIND_INSERT;
        else if (pick >= 97)
            kind = KIND_UNUSED;
        else if (pick < insert_pct + (97 - insert_pct) / 2)
            kind = KIND_REMOVE;
        else
            kind = KIND_READ;
        if (key_mode < 5)
            key = $urandom;
        else if (key_mode < 8)
            key = $urandom_range(8) - 4;
        else if (key_mode == 8)
            key = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else
            key = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                    : 32'h8000_0000 + $urandom_range(3);
        send_op(kind, key, 4'($urandom_range(15)));
    endtask

    // Stops offering and waits until every predicted word has come out.
    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (results_pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input int insert_pct, input bit long_hold);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct <= stall_pct;
        if (long_hold)
            hold_requests <= hold_requests + 1;
        repeat (PHASE_WORDS)
            send_random_op(insert_pct);
        wait_drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, unused kind, extreme and equal keys.
        send_op(KIND_READ, 32'h0, 4'd0);
        send_op(KIND_REMOVE, 32'hFFFF_FFFF, 4'd15);
        send_op(KIND_UNUSED, 32'hA5A5_5A5A, 4'd9);
        send_op(KIND_INSERT, 32'h7FFF_FFFF, 4'd0);
        send_op(KIND_INSERT, 32'h8000_0000, 4'd0);
        send_op(KIND_INSERT, 32'h0000_0000, 4'd0);
        send_op(KIND_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_op(KIND_INSERT, 32'h0000_0000, 4'd15);
        send_op(KIND_READ, 32'h0, 4'd0);
        send_op(KIND_READ, 32'h0, 4'd4);
        send_op(KIND_READ, 32'h0, 4'd5);
        send_op(KIND_REMOVE, 32'h0, 4'd5);
        // Fill the list, then insert into a full list and work at its ends.
        repeat (11)
            send_op(KIND_INSERT, $urandom, 4'($urandom_range(15)));
        send_op(KIND_INSERT, 32'h1234_5678, 4'd0);
        send_op(KIND_READ, 32'h0, 4'd15);
        send_op(KIND_REMOVE, 32'h0, 4'd15);
        send_op(KIND_REMOVE, 32'h0, 4'd0);
        wait_drain();

        // Random phases; insert-heavy and remove-heavy mixes move the count
        // between full and empty.
        run_phase(0, 0, 55, 1'b0);
        run_phase(55, 0, 30, 1'b0);
        run_phase(0, 55, 55, 1'b0);
        run_phase(35, 35, 25, 1'b0);
        run_phase(0, 0, 45, 1'b1);
        run_phase(35, 35, 40, 1'b0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit well beyond the slowest correct run.
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
design/slri_pkg.sv
design/slri_cell.sv
design/sorted_list_insert_remove_unit.sv
design/slri_checker.sv
sim/sorted_list_insert_remove_unit_checker.sv
sim/sorted_list_insert_remove_unit_tb.sv
